// ----- rtl/stc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stc_pkg
// Shared types, codes and character tables for the source character tokenizer.
// ----------------------------------------------------------------------------
package stc_pkg;

   localparam int QUEUE_DEPTH = 4;

   // scan states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_NUM   = 4'd1;
   localparam logic [3:0] ST_IDENT = 4'd2;
   localparam logic [3:0] ST_OPH   = 4'd3;
   localparam logic [3:0] ST_STR   = 4'd4;
   localparam logic [3:0] ST_ESC   = 4'd5;
   localparam logic [3:0] ST_LCOM  = 4'd6;
   localparam logic [3:0] ST_BCOM  = 4'd7;
   localparam logic [3:0] ST_BSTAR = 4'd8;

   // token kinds
   localparam logic [2:0] K_NUM   = 3'd0;
   localparam logic [2:0] K_IDENT = 3'd1;
   localparam logic [2:0] K_OP    = 3'd2;
   localparam logic [2:0] K_SEP   = 3'd3;
   localparam logic [2:0] K_STR   = 3'd4;
   localparam logic [2:0] K_COM   = 3'd5;
   localparam logic [2:0] K_UNK   = 3'd6;

   localparam int NUM_KW = 6;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_EQ     = 8'h3D;

   typedef struct packed {
      logic [2:0] token_kind;
      logic       has_char;
      logic [7:0] char_value;
      logic       token_end;
      logic       known_keyword;
   } result_type;

   // up to two results caused by one input item
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } bundle_type;

   function automatic result_type make_result(logic [2:0] kind, logic has,
                                              logic [7:0] ch, logic tend,
                                              logic kw);
      result_type r;
      r.token_kind    = kind;
      r.has_char      = has;
      r.char_value    = has ? ch : 8'h00;
      r.token_end     = tend;
      r.known_keyword = kw;
      return r;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_op(logic [7:0] c);
      return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
             (c == "=") || (c == "!");
   endfunction

   function automatic logic is_sep(logic [7:0] c);
      return (c == "(") || (c == ")") || (c == ";") || (c == "{") || (c == "}");
   endfunction

   // keyword text, left aligned, first character in the top byte
   function automatic logic [47:0] kw_word(logic [2:0] k);
      logic [47:0] w;
      case (k)
         3'd0:    w = {"exit", 16'h0000};
         3'd1:    w = {"if", 32'h0000_0000};
         3'd2:    w = {"else", 16'h0000};
         3'd3:    w = {"for", 24'h00_0000};
         3'd4:    w = {"while", 8'h00};
         3'd5:    w = "printf";
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic logic [2:0] kw_len(logic [2:0] k);
      logic [2:0] n;
      case (k)
         3'd0:    n = 3'd4;
         3'd1:    n = 3'd2;
         3'd2:    n = 3'd4;
         3'd3:    n = 3'd3;
         3'd4:    n = 3'd5;
         3'd5:    n = 3'd6;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // drop keywords that no longer match after character c at position p
   function automatic logic [5:0] kw_update(logic [5:0] cand, logic [2:0] p,
                                            logic [7:0] c);
      logic [5:0]  nc;
      logic [47:0] w;
      nc = cand;
      for (int k = 0; k < NUM_KW; k++) begin
         w = kw_word(3'(k));
         if ((p >= kw_len(3'(k))) || (p > 3'd5)) begin
            nc[k] = 1'b0;
         end else if (w[8*(5-int'(p)) +: 8] != c) begin
            nc[k] = 1'b0;
         end
      end
      return nc;
   endfunction

   function automatic logic kw_known(logic [5:0] cand, logic [2:0] len);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < NUM_KW; k++) begin
         if (cand[k] && (kw_len(3'(k)) == len)) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/stc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stc_front
// Scanner: accepts one byte per cycle while accept is high, keeps the token
// state and builds the bundle of results that each item causes.
// ----------------------------------------------------------------------------
module stc_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         byte_in,
   input  wire logic               flush,
   output logic                    bundle_write,
   output stc_pkg::bundle_type     bundle
);

   logic [3:0] state_ff, state_in;
   logic [7:0] held_ff, held_in;
   logic [5:0] cand_ff, cand_in;
   logic [2:0] len_ff, len_in;

   stc_pkg::result_type res [2];
   logic [1:0]          cnt;

   // outcome of a byte seen between tokens
   logic                sb_emit;
   stc_pkg::result_type sb_res;
   logic [3:0]          sb_state;
   logic                sb_ident;
   logic                sb_held;

   always_comb begin
      sb_emit  = 1'b0;
      sb_res   = stc_pkg::make_result(stc_pkg::K_UNK, 1'b1, byte_in, 1'b1, 1'b0);
      sb_state = stc_pkg::ST_IDLE;
      sb_ident = 1'b0;
      sb_held  = 1'b0;
      if (stc_pkg::is_space(byte_in)) begin
         sb_emit = 1'b0;
      end else if (byte_in == stc_pkg::CH_QUOTE) begin
         sb_state = stc_pkg::ST_STR;
      end else if (stc_pkg::is_sep(byte_in)) begin
         sb_emit = 1'b1;
         sb_res  = stc_pkg::make_result(stc_pkg::K_SEP, 1'b1, byte_in, 1'b1, 1'b0);
      end else if (stc_pkg::is_digit(byte_in)) begin
         sb_emit  = 1'b1;
         sb_res   = stc_pkg::make_result(stc_pkg::K_NUM, 1'b1, byte_in, 1'b0, 1'b0);
         sb_state = stc_pkg::ST_NUM;
      end else if (stc_pkg::is_alpha(byte_in)) begin
         sb_emit  = 1'b1;
         sb_res   = stc_pkg::make_result(stc_pkg::K_IDENT, 1'b1, byte_in, 1'b0, 1'b0);
         sb_state = stc_pkg::ST_IDENT;
         sb_ident = 1'b1;
      end else if (stc_pkg::is_op(byte_in)) begin
         sb_state = stc_pkg::ST_OPH;
         sb_held  = 1'b1;
      end else begin
         sb_emit = 1'b1;
      end
   end

   always_comb begin
      logic do_start;
      do_start = 1'b0;
      res[0]   = '0;
      res[1]   = '0;
      cnt      = 2'd0;
      state_in = state_ff;
      held_in  = held_ff;
      cand_in  = cand_ff;
      len_in   = len_ff;

      if (flush) begin
         state_in = stc_pkg::ST_IDLE;
         case (state_ff)
            stc_pkg::ST_NUM: begin
               res[0] = stc_pkg::make_result(stc_pkg::K_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
               cnt    = 2'd1;
            end
            stc_pkg::ST_IDENT: begin
               res[0] = stc_pkg::make_result(stc_pkg::K_IDENT, 1'b0, 8'h00, 1'b1,
                                             stc_pkg::kw_known(cand_ff, len_ff));
               cnt    = 2'd1;
            end
            stc_pkg::ST_OPH: begin
               res[0] = stc_pkg::make_result(stc_pkg::K_OP, 1'b1, held_ff, 1'b1, 1'b0);
               cnt    = 2'd1;
            end
            stc_pkg::ST_STR, stc_pkg::ST_ESC: begin
               res[0] = stc_pkg::make_result(stc_pkg::K_STR, 1'b0, 8'h00, 1'b1, 1'b0);
               cnt    = 2'd1;
            end
            stc_pkg::ST_LCOM, stc_pkg::ST_BCOM: begin
               res[0] = stc_pkg::make_result(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
               cnt    = 2'd1;
            end
            stc_pkg::ST_BSTAR: begin
               res[0] = stc_pkg::make_result(stc_pkg::K_COM, 1'b1, stc_pkg::CH_STAR,
                                             1'b0, 1'b0);
               res[1] = stc_pkg::make_result(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
               cnt    = 2'd2;
            end
            default: cnt = 2'd0;
         endcase
      end else begin
         case (state_ff)
            stc_pkg::ST_NUM: begin
               if (stc_pkg::is_digit(byte_in)) begin
                  res[0] = stc_pkg::make_result(stc_pkg::K_NUM, 1'b1, byte_in, 1'b0, 1'b0);
                  cnt    = 2'd1;
               end else begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
                  cnt      = 2'd1;
                  do_start = 1'b1;
               end
            end
            stc_pkg::ST_IDENT: begin
               if (stc_pkg::is_alpha(byte_in)) begin
                  cand_in = stc_pkg::kw_update(cand_ff, len_ff, byte_in);
                  len_in  = (len_ff == 3'd7) ? len_ff : len_ff + 3'd1;
                  res[0]  = stc_pkg::make_result(stc_pkg::K_IDENT, 1'b1, byte_in,
                                                 1'b0, 1'b0);
                  cnt     = 2'd1;
               end else begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_IDENT, 1'b0, 8'h00, 1'b1,
                                                  stc_pkg::kw_known(cand_ff, len_ff));
                  cnt      = 2'd1;
                  do_start = 1'b1;
               end
            end
            stc_pkg::ST_OPH: begin
               if (byte_in == stc_pkg::CH_EQ) begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_OP, 1'b1, held_ff, 1'b0, 1'b0);
                  res[1]   = stc_pkg::make_result(stc_pkg::K_OP, 1'b1, stc_pkg::CH_EQ,
                                                  1'b1, 1'b0);
                  cnt      = 2'd2;
                  state_in = stc_pkg::ST_IDLE;
               end else if ((held_ff == stc_pkg::CH_SLASH) &&
                            (byte_in == stc_pkg::CH_SLASH)) begin
                  state_in = stc_pkg::ST_LCOM;
               end else if ((held_ff == stc_pkg::CH_SLASH) &&
                            (byte_in == stc_pkg::CH_STAR)) begin
                  state_in = stc_pkg::ST_BCOM;
               end else begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_OP, 1'b1, held_ff, 1'b1, 1'b0);
                  cnt      = 2'd1;
                  do_start = 1'b1;
               end
            end
            stc_pkg::ST_STR: begin
               if (byte_in == stc_pkg::CH_QUOTE) begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_STR, 1'b0, 8'h00, 1'b1, 1'b0);
                  cnt      = 2'd1;
                  state_in = stc_pkg::ST_IDLE;
               end else if (byte_in == stc_pkg::CH_BSLASH) begin
                  state_in = stc_pkg::ST_ESC;
               end else begin
                  res[0] = stc_pkg::make_result(stc_pkg::K_STR, 1'b1, byte_in, 1'b0, 1'b0);
                  cnt    = 2'd1;
               end
            end
            stc_pkg::ST_ESC: begin
               // escape translation: n and t only
               res[0]   = stc_pkg::make_result(stc_pkg::K_STR, 1'b1,
                             (byte_in == "n") ? stc_pkg::CH_LF :
                             ((byte_in == "t") ? stc_pkg::CH_TAB : byte_in), 1'b0, 1'b0);
               cnt      = 2'd1;
               state_in = stc_pkg::ST_STR;
            end
            stc_pkg::ST_LCOM: begin
               if (byte_in == stc_pkg::CH_LF) begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
                  cnt      = 2'd1;
                  state_in = stc_pkg::ST_IDLE;
               end else begin
                  res[0] = stc_pkg::make_result(stc_pkg::K_COM, 1'b1, byte_in, 1'b0, 1'b0);
                  cnt    = 2'd1;
               end
            end
            stc_pkg::ST_BCOM: begin
               if (byte_in == stc_pkg::CH_STAR) begin
                  state_in = stc_pkg::ST_BSTAR;
               end else begin
                  res[0] = stc_pkg::make_result(stc_pkg::K_COM, 1'b1, byte_in, 1'b0, 1'b0);
                  cnt    = 2'd1;
               end
            end
            stc_pkg::ST_BSTAR: begin
               if (byte_in == stc_pkg::CH_SLASH) begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
                  cnt      = 2'd1;
                  state_in = stc_pkg::ST_IDLE;
               end else if (byte_in == stc_pkg::CH_STAR) begin
                  res[0] = stc_pkg::make_result(stc_pkg::K_COM, 1'b1, stc_pkg::CH_STAR,
                                                1'b0, 1'b0);
                  cnt    = 2'd1;
               end else begin
                  res[0]   = stc_pkg::make_result(stc_pkg::K_COM, 1'b1, stc_pkg::CH_STAR,
                                                  1'b0, 1'b0);
                  res[1]   = stc_pkg::make_result(stc_pkg::K_COM, 1'b1, byte_in, 1'b0, 1'b0);
                  cnt      = 2'd2;
                  state_in = stc_pkg::ST_BCOM;
               end
            end
            default: do_start = 1'b1;
         endcase

         if (do_start) begin
            state_in = sb_state;
            if (sb_emit) begin
               res[cnt[0]] = sb_res;
               cnt         = cnt + 2'd1;
            end
            if (sb_ident) begin
               cand_in = stc_pkg::kw_update(6'h3F, 3'd0, byte_in);
               len_in  = 3'd1;
            end
            if (sb_held) held_in = byte_in;
         end
      end
   end

   assign bundle_write = accept && (cnt != 2'd0);
   assign bundle.two   = cnt[1];
   assign bundle.r0    = res[0];
   assign bundle.r1    = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stc_pkg::ST_IDLE;
         held_ff  <= 8'h00;
         cand_ff  <= 6'h3F;
         len_ff   <= 3'd0;
      end else if (accept) begin
         state_ff <= state_in;
         held_ff  <= held_in;
         cand_ff  <= cand_in;
         len_ff   <= len_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/stc_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stc_queue
// Short queue of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stc_queue #(
   parameter int Depth = stc_pkg::QUEUE_DEPTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire stc_pkg::bundle_type wr_data,
   output logic                     full,
   input  wire logic                rd_en,
   output stc_pkg::bundle_type      rd_data,
   output logic                     empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   stc_pkg::bundle_type   mem_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/stc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stc_back
// Output stage: holds one bundle and hands its results out one item at a time.
// ----------------------------------------------------------------------------
module stc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire stc_pkg::bundle_type q_data,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire logic                pop,
   output logic                     empty,
   output stc_pkg::result_type      res,
   output logic                     last
);

   stc_pkg::bundle_type cur_ff;
   logic                valid_ff, valid_in;
   logic                phase_ff, phase_in;
   logic                take;
   logic                final_res;

   assign take      = pop && valid_ff;
   assign final_res = phase_ff || !cur_ff.two;
   assign empty     = !valid_ff;
   assign res       = phase_ff ? cur_ff.r1 : cur_ff.r0;
   assign last      = final_res;

   always_comb begin
      q_pop    = 1'b0;
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (!valid_ff || (take && final_res)) begin
         q_pop    = !q_empty;
         valid_in = !q_empty;
         phase_in = 1'b0;
      end else if (take) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/source_char_tokenizer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// source_char_tokenizer_top
// Streaming tokenizer: source bytes in, tagged token characters out.
// ----------------------------------------------------------------------------
// path: a result goes into the bundle queue when its byte is taken, then into
//   the output stage register, from which it can be popped
// throughput: one byte per cycle unless the queue is full; a byte causing two
//   results takes two pops at the output; the bundle queue absorbs short bursts
// reset: synchronous, clears scanner state to idle and empties queue and output
// ----------------------------------------------------------------------------
module source_char_tokenizer_top #(
   parameter int QueueDepth = stc_pkg::QUEUE_DEPTH
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_flush,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [2:0]      rsp_token_kind,
   output logic            rsp_has_char,
   output logic [7:0]      rsp_char_value,
   output logic            rsp_token_end,
   output logic            rsp_known_keyword,
   output logic            rsp_last
);

   logic                accept;
   logic                bundle_write;
   stc_pkg::bundle_type bundle;
   stc_pkg::bundle_type q_data;
   logic                q_empty;
   logic                q_pop;
   stc_pkg::result_type res;

   assign accept = req_push && !req_full;

   stc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .byte_in      (req_byte_in),
      .flush        (req_flush),
      .bundle_write (bundle_write),
      .bundle       (bundle)
   );

   stc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bundle_write),
      .wr_data (bundle),
      .full    (req_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   stc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (q_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .res     (res),
      .last    (rsp_last)
   );

   assign rsp_token_kind    = res.token_kind;
   assign rsp_has_char      = res.has_char;
   assign rsp_char_value    = res.char_value;
   assign rsp_token_end     = res.token_end;
   assign rsp_known_keyword = res.known_keyword;

endmodule
`default_nettype wire

// ----- rtl/stc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stc_checker
// Port-level checks on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module stc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_full,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [2:0] rsp_token_kind,
   input wire logic       rsp_has_char,
   input wire logic [7:0] rsp_char_value,
   input wire logic       rsp_token_end,
   input wire logic       rsp_known_keyword,
   input wire logic       rsp_last
);

   // a waiting item holds until it is taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_token_kind) &&
         $stable(rsp_char_value) && $stable(rsp_token_end) && $stable(rsp_last)))
      else $error("waiting item changed before pop");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queue not empty after reset");

   a_no_char: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_has_char) |-> (rsp_char_value == 8'h00 && rsp_token_end))
      else $error("charless item that is not a token end");

   a_keyword: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_known_keyword) |->
         (rsp_token_end && !rsp_has_char && rsp_token_kind == stc_pkg::K_IDENT))
      else $error("keyword flag off an identifier end");

   // an unknown byte is a whole token on its own
   a_unknown: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_token_kind == stc_pkg::K_UNK) |->
         (rsp_has_char && rsp_token_end && rsp_last))
      else $error("unknown item malformed");

endmodule

bind source_char_tokenizer_top stc_checker u_stc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_has_char      (rsp_has_char),
   .rsp_char_value    (rsp_char_value),
   .rsp_token_end     (rsp_token_end),
   .rsp_known_keyword (rsp_known_keyword),
   .rsp_last          (rsp_last)
);
`default_nettype wire

// ----- tb/source_char_tokenizer_top_tb.sv -----
// ----------------------------------------------------------------------------
// source_char_tokenizer_top_tb
// Feeds source bytes into the tokenizer and checks every token character
// against a behavioural scanner kept in the bench. A short table of directed
// bytes comes first, then random fragments of source text (keywords, names,
// numbers, operators, strings, comments, noise, flushes) under varying
// back-pressure on both queue sides.
// ----------------------------------------------------------------------------
module source_char_tokenizer_top_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int ITEMS_PER_PHASE = 64;

   typedef struct packed {
      logic [2:0] kind;
      logic       has;
      logic [7:0] ch;
      logic       tend;
      logic       kw;
      logic       last;
   } tok_type;

   typedef struct packed {
      logic [7:0] b;
      logic       fl;
   } src_item_type;

   typedef struct {
      logic [7:0] b;
      logic       fl;
      logic       typed;
      logic [2:0] kind;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_byte_in = 8'h00;
   logic       req_flush = 1'b0;
   logic       rsp_pop = 1'b0;
   logic       req_full;
   logic       rsp_empty;
   logic [2:0] rsp_token_kind;
   logic       rsp_has_char;
   logic [7:0] rsp_char_value;
   logic       rsp_token_end;
   logic       rsp_known_keyword;
   logic       rsp_last;

   // scanner copy kept by the bench
   logic [3:0] scan_st = stc_pkg::ST_IDLE;
   logic [7:0] held_op = 8'h00;
   logic [5:0] kw_cand = 6'h3F;
   logic [2:0] id_len = 3'd0;

   string kw_names [6] = '{"exit", "if", "else", "for", "while", "printf"};
   string op_chars = "+-*/=!";
   string sep_chars = "();{}";

   tok_type      step_toks[$];
   tok_type      tok_expect_q[$];
   src_item_type src_q[$];
   dir_row_type  dir_rows[$];

   int send_gap_pct = 0;
   int recv_gap_pct = 0;
   int live_items = 0;
   int mismatches = 0;
   int cycles = 0;

   source_char_tokenizer_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_byte_in       (req_byte_in),
      .req_flush         (req_flush),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_has_char      (rsp_has_char),
      .rsp_char_value    (rsp_char_value),
      .rsp_token_end     (rsp_token_end),
      .rsp_known_keyword (rsp_known_keyword),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // character classes
   // ------------------------------------------------------------------
   function automatic bit is_num_char(logic [7:0] c);
      return c >= 8'd48 && c <= 8'd57;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit in_set(string s, logic [7:0] c);
      bit hit;
      hit = 1'b0;
      for (int i = 0; i < s.len(); i++) begin
         if (s[i] == c) hit = 1'b1;
      end
      return hit;
   endfunction

   // ------------------------------------------------------------------
   // scanner
   // ------------------------------------------------------------------
   function automatic void emit(logic [2:0] kind, logic has, logic [7:0] ch, logic tend,
                                logic kw);
      tok_type t;
      t.kind = kind;
      t.has  = has;
      t.ch   = has ? ch : 8'h00;
      t.tend = tend;
      t.kw   = kw;
      t.last = 1'b0;
      step_toks.push_back(t);
   endfunction

   function automatic void ident_step(logic [7:0] c);
      for (int k = 0; k < 6; k++) begin
         if (id_len >= kw_names[k].len() || kw_names[k][id_len] != c) kw_cand[k] = 1'b0;
      end
      if (id_len < 3'd7) id_len = id_len + 3'd1;
   endfunction

   function automatic logic ident_is_kw();
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 6; k++) begin
         if (kw_cand[k] && kw_names[k].len() == id_len) hit = 1'b1;
      end
      return hit;
   endfunction

   // a byte seen between tokens
   function automatic void open_token(logic [7:0] c);
      scan_st = stc_pkg::ST_IDLE;
      if (!is_blank(c)) begin
         if (c == stc_pkg::CH_QUOTE) begin
            scan_st = stc_pkg::ST_STR;
         end else if (in_set(sep_chars, c)) begin
            emit(stc_pkg::K_SEP, 1'b1, c, 1'b1, 1'b0);
         end else if (is_num_char(c)) begin
            emit(stc_pkg::K_NUM, 1'b1, c, 1'b0, 1'b0);
            scan_st = stc_pkg::ST_NUM;
         end else if (is_letter(c)) begin
            kw_cand = 6'h3F;
            id_len = 3'd0;
            ident_step(c);
            emit(stc_pkg::K_IDENT, 1'b1, c, 1'b0, 1'b0);
            scan_st = stc_pkg::ST_IDENT;
         end else if (in_set(op_chars, c)) begin
            held_op = c;
            scan_st = stc_pkg::ST_OPH;
         end else begin
            emit(stc_pkg::K_UNK, 1'b1, c, 1'b1, 1'b0);
         end
      end
   endfunction

   function automatic void tokenize_byte(logic [7:0] c, logic fl);
      step_toks.delete();
      if (fl) begin
         case (scan_st)
            stc_pkg::ST_NUM:   emit(stc_pkg::K_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
            stc_pkg::ST_IDENT: emit(stc_pkg::K_IDENT, 1'b0, 8'h00, 1'b1, ident_is_kw());
            stc_pkg::ST_OPH:   emit(stc_pkg::K_OP, 1'b1, held_op, 1'b1, 1'b0);
            stc_pkg::ST_STR, stc_pkg::ST_ESC:
               emit(stc_pkg::K_STR, 1'b0, 8'h00, 1'b1, 1'b0);
            stc_pkg::ST_LCOM, stc_pkg::ST_BCOM:
               emit(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
            stc_pkg::ST_BSTAR: begin
               emit(stc_pkg::K_COM, 1'b1, stc_pkg::CH_STAR, 1'b0, 1'b0);
               emit(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
            end
            default: ;
         endcase
         scan_st = stc_pkg::ST_IDLE;
      end else begin
         case (scan_st)
            stc_pkg::ST_NUM: begin
               if (is_num_char(c)) begin
                  emit(stc_pkg::K_NUM, 1'b1, c, 1'b0, 1'b0);
               end else begin
                  emit(stc_pkg::K_NUM, 1'b0, 8'h00, 1'b1, 1'b0);
                  open_token(c);
               end
            end
            stc_pkg::ST_IDENT: begin
               if (is_letter(c)) begin
                  ident_step(c);
                  emit(stc_pkg::K_IDENT, 1'b1, c, 1'b0, 1'b0);
               end else begin
                  emit(stc_pkg::K_IDENT, 1'b0, 8'h00, 1'b1, ident_is_kw());
                  open_token(c);
               end
            end
            stc_pkg::ST_OPH: begin
               if (c == stc_pkg::CH_EQ) begin
                  emit(stc_pkg::K_OP, 1'b1, held_op, 1'b0, 1'b0);
                  emit(stc_pkg::K_OP, 1'b1, stc_pkg::CH_EQ, 1'b1, 1'b0);
                  scan_st = stc_pkg::ST_IDLE;
               end else if (held_op == stc_pkg::CH_SLASH && c == stc_pkg::CH_SLASH) begin
                  scan_st = stc_pkg::ST_LCOM;
               end else if (held_op == stc_pkg::CH_SLASH && c == stc_pkg::CH_STAR) begin
                  scan_st = stc_pkg::ST_BCOM;
               end else begin
                  emit(stc_pkg::K_OP, 1'b1, held_op, 1'b1, 1'b0);
                  open_token(c);
               end
            end
            stc_pkg::ST_STR: begin
               if (c == stc_pkg::CH_QUOTE) begin
                  emit(stc_pkg::K_STR, 1'b0, 8'h00, 1'b1, 1'b0);
                  scan_st = stc_pkg::ST_IDLE;
               end else if (c == stc_pkg::CH_BSLASH) begin
                  scan_st = stc_pkg::ST_ESC;
               end else begin
                  emit(stc_pkg::K_STR, 1'b1, c, 1'b0, 1'b0);
               end
            end
            stc_pkg::ST_ESC: begin
               emit(stc_pkg::K_STR, 1'b1,
                    (c == "n") ? stc_pkg::CH_LF : ((c == "t") ? stc_pkg::CH_TAB : c),
                    1'b0, 1'b0);
               scan_st = stc_pkg::ST_STR;
            end
            stc_pkg::ST_LCOM: begin
               if (c == stc_pkg::CH_LF) begin
                  emit(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
                  scan_st = stc_pkg::ST_IDLE;
               end else begin
                  emit(stc_pkg::K_COM, 1'b1, c, 1'b0, 1'b0);
               end
            end
            stc_pkg::ST_BCOM: begin
               if (c == stc_pkg::CH_STAR) scan_st = stc_pkg::ST_BSTAR;
               else emit(stc_pkg::K_COM, 1'b1, c, 1'b0, 1'b0);
            end
            stc_pkg::ST_BSTAR: begin
               if (c == stc_pkg::CH_SLASH) begin
                  emit(stc_pkg::K_COM, 1'b0, 8'h00, 1'b1, 1'b0);
                  scan_st = stc_pkg::ST_IDLE;
               end else if (c == stc_pkg::CH_STAR) begin
                  emit(stc_pkg::K_COM, 1'b1, stc_pkg::CH_STAR, 1'b0, 1'b0);
               end else begin
                  emit(stc_pkg::K_COM, 1'b1, stc_pkg::CH_STAR, 1'b0, 1'b0);
                  emit(stc_pkg::K_COM, 1'b1, c, 1'b0, 1'b0);
                  scan_st = stc_pkg::ST_BCOM;
               end
            end
            default: open_token(c);
         endcase
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // sending side
   // ------------------------------------------------------------------
   task automatic send_item(input logic [7:0] b, input logic fl, input logic typed,
                            input logic [2:0] kind);
      tok_type t;
      while ($urandom_range(99) < send_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_byte_in <= b;
      req_flush <= fl;
      @(posedge clock);
      while (req_full) @(posedge clock);
      tokenize_byte(b, fl);
      // table rows with the answer written out replace the scanner's results
      if (typed) begin
         step_toks.delete();
         if (!fl) begin
            t = '{kind: kind, has: 1'b1, ch: b, tend: 1'b1, kw: 1'b0, last: 1'b1};
            step_toks.push_back(t);
         end
      end
      foreach (step_toks[i]) tok_expect_q.push_back(step_toks[i]);
      live_items++;
   endtask

   task automatic wait_drained();
      while (tok_expect_q.size() != 0) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic void add_row(logic [7:0] b, logic fl, logic typed, logic [2:0] kind);
      dir_row_type r;
      r.b = b;
      r.fl = fl;
      r.typed = typed;
      r.kind = kind;
      dir_rows.push_back(r);
   endfunction

   function automatic void add_src(logic [7:0] b, logic fl);
      src_item_type s;
      s.b = b;
      s.fl = fl;
      src_q.push_back(s);
   endfunction

   function automatic logic [7:0] any_letter();
      return ($urandom_range(1) != 0) ? 8'd97 + 8'($urandom_range(25))
                                      : 8'd65 + 8'($urandom_range(25));
   endfunction

   // one random piece of source text, mostly well formed
   function automatic void add_fragment();
      int         sel;
      int         n;
      int         k;
      logic [7:0] c;
      sel = $urandom_range(99);
      if (sel < 12) begin
         k = $urandom_range(5);
         for (int i = 0; i < kw_names[k].len(); i++) add_src(kw_names[k][i], 1'b0);
         if ($urandom_range(3) == 0) add_src(any_letter(), 1'b0);
      end else if (sel < 24) begin
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++) add_src(any_letter(), 1'b0);
      end else if (sel < 34) begin
         n = $urandom_range(1, 5);
         for (int i = 0; i < n; i++) add_src(8'd48 + 8'($urandom_range(9)), 1'b0);
      end else if (sel < 46) begin
         add_src(op_chars[$urandom_range(5)], 1'b0);
         if ($urandom_range(1) != 0) add_src(stc_pkg::CH_EQ, 1'b0);
      end else if (sel < 52) begin
         add_src(sep_chars[$urandom_range(4)], 1'b0);
      end else if (sel < 62) begin
         add_src(stc_pkg::CH_QUOTE, 1'b0);
         n = $urandom_range(6);
         for (int i = 0; i < n; i++) begin
            k = $urandom_range(9);
            if (k < 3) begin
               add_src(stc_pkg::CH_BSLASH, 1'b0);
               c = (k == 0) ? 8'h6E : ((k == 1) ? 8'h74 : 8'($urandom_range(255)));
               add_src(c, 1'b0);
            end else if (k < 8) begin
               add_src(8'($urandom_range(32, 126)), 1'b0);
            end else begin
               add_src(8'($urandom_range(255)), 1'b0);
            end
         end
         if ($urandom_range(4) != 0) add_src(stc_pkg::CH_QUOTE, 1'b0);
      end else if (sel < 70) begin
         add_src(stc_pkg::CH_SLASH, 1'b0);
         add_src(stc_pkg::CH_SLASH, 1'b0);
         n = $urandom_range(5);
         for (int i = 0; i < n; i++) add_src(8'($urandom_range(255)), 1'b0);
         if ($urandom_range(6) != 0) add_src(stc_pkg::CH_LF, 1'b0);
      end else if (sel < 78) begin
         add_src(stc_pkg::CH_SLASH, 1'b0);
         add_src(stc_pkg::CH_STAR, 1'b0);
         n = $urandom_range(6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(2) == 0) add_src(stc_pkg::CH_STAR, 1'b0);
            else add_src(8'($urandom_range(255)), 1'b0);
         end
         if ($urandom_range(6) != 0) begin
            add_src(stc_pkg::CH_STAR, 1'b0);
            add_src(stc_pkg::CH_SLASH, 1'b0);
         end
      end else if (sel < 86) begin
         add_src(($urandom_range(1) != 0) ? 8'd32 : 8'($urandom_range(9, 13)), 1'b0);
      end else if (sel < 94) begin
         add_src(8'($urandom_range(255)), 1'b0);
      end else begin
         add_src(8'($urandom_range(255)), 1'b1);
      end
      if ($urandom_range(1) != 0) add_src(8'd32, 1'b0);
   endfunction

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      tok_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (tok_expect_q.size() == 0) begin
            $display("%0t: unexpected item, expected none, got kind %0h char %0h", $time,
                     rsp_token_kind, rsp_char_value);
            mismatches++;
         end else begin
            e = tok_expect_q.pop_front();
            check_field("token_kind", 8'(e.kind), 8'(rsp_token_kind));
            check_field("has_char", 8'(e.has), 8'(rsp_has_char));
            check_field("char_value", e.ch, rsp_char_value);
            check_field("token_end", 8'(e.tend), 8'(rsp_token_end));
            check_field("known_keyword", 8'(e.kw), 8'(rsp_known_keyword));
            check_field("last", 8'(e.last), 8'(rsp_last));
         end
      end
      rsp_pop <= ($urandom_range(99) >= recv_gap_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("source_char_tokenizer_top_tb failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      src_item_type s;
      // flush in idle and lone bytes with an obvious answer
      add_row(8'h00, 1'b1, 1'b1, stc_pkg::K_UNK);
      add_row(8'h00, 1'b0, 1'b1, stc_pkg::K_UNK);
      add_row(8'hFF, 1'b0, 1'b1, stc_pkg::K_UNK);
      add_row("}", 1'b0, 1'b1, stc_pkg::K_SEP);
      // keyword closed by a digit, number closed by an operator pair
      add_row("i", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row("f", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row("9", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row("+", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_EQ, 1'b0, 1'b0, stc_pkg::K_NUM);
      // string with a newline escape
      add_row(stc_pkg::CH_QUOTE, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_BSLASH, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row("n", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_QUOTE, 1'b0, 1'b0, stc_pkg::K_NUM);
      // block comment flushed on a pending star
      add_row(stc_pkg::CH_SLASH, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_STAR, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row("a", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_STAR, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(8'h00, 1'b1, 1'b0, stc_pkg::K_NUM);
      // line comment ended by a line feed
      add_row(stc_pkg::CH_SLASH, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_SLASH, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row("q", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_LF, 1'b0, 1'b0, stc_pkg::K_NUM);
      // held operator closed by flush, lone slash closed by a separator
      add_row("-", 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(8'hA5, 1'b1, 1'b0, stc_pkg::K_NUM);
      add_row(stc_pkg::CH_SLASH, 1'b0, 1'b0, stc_pkg::K_NUM);
      add_row(";", 1'b0, 1'b0, stc_pkg::K_NUM);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_gap_pct = 36;
      recv_gap_pct = 60;
      foreach (dir_rows[i]) send_item(dir_rows[i].b, dir_rows[i].fl, dir_rows[i].typed,
                                      dir_rows[i].kind);
      live_items = 0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_gap_pct = 36;
               recv_gap_pct = 60;
            end
            1: begin
               send_gap_pct = 60;
               recv_gap_pct = 36;
            end
            default: begin
               send_gap_pct = 0;
               recv_gap_pct = 0;
            end
         endcase
         wait_drained();
         while (live_items < (phase + 1) * ITEMS_PER_PHASE) begin
            add_fragment();
            while (src_q.size() != 0) begin
               s = src_q.pop_front();
               send_item(s.b, s.fl, 1'b0, stc_pkg::K_NUM);
            end
            if ($urandom_range(19) == 0) wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("source_char_tokenizer_top_tb passed");
      end else begin
         $display("source_char_tokenizer_top_tb failed");
      end
      $finish;
   end

endmodule
